@@ sv/grl_pkg.sv @@
// ----------------------------------------------------------------------------
// grl_pkg
// Shared constants and sequencer states for the grid layout row chooser.
// ----------------------------------------------------------------------------
package grl_pkg;

  // Default configuration
  localparam int MaxCellsDef = 16;
  localparam int DimBitsDef  = 12;

  // Scores at or above this never win
  localparam logic [30:0] IntMax = 31'h7FFF_FFFF;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SC_BASE,
    ST_SC_RH,
    ST_SC_W1,
    ST_SC_W23,
    ST_SC_N1,
    ST_SC_SQ,
    ST_SC_CNT,
    ST_SC_ACC,
    ST_SC_CMP,
    ST_LY_BASE,
    ST_LY_RH,
    ST_LY_ROW,
    ST_LY_COLW,
    ST_LY_EMIT
  } grl_state_e;

endpackage

@@ sv/grid_layout_row_chooser.sv @@
// ----------------------------------------------------------------------------
// grid_layout_row_chooser
// Picks the row count for a grid of cells and streams out one rectangle per
// cell in row-major order.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall_o stays high until the last
// rectangle of the request sits in the output register. All work runs through
// one bit-serial restoring divider (DV_W = max(DIM_BITS, count width) bits
// wide) and one shared multiplier under a small sequencer. A request of n
// cells (n > 1, nonzero area) scores every candidate row count from 1 to n,
// then sets up the layout, divides the width once per row and emits one
// cell per cycle unless the output is stalled. A count of zero is taken and
// gives nothing; counts above MAX_CELLS saturate.
module grid_layout_row_chooser #(
  parameter int MAX_CELLS = grl_pkg::MaxCellsDef,
  parameter int DIM_BITS  = grl_pkg::DimBitsDef,
  localparam int CNT_W    = $clog2(MAX_CELLS + 1),
  localparam int IDX_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CNT_W-1:0]    cell_count_i,
  input  logic [DIM_BITS-1:0] area_width_i,
  input  logic [DIM_BITS-1:0] area_height_i,
  // rectangle channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IDX_W-1:0]    cell_index_o,
  output logic [DIM_BITS-1:0] cell_x_o,
  output logic [DIM_BITS-1:0] cell_y_o,
  output logic [DIM_BITS-1:0] cell_width_o,
  output logic [DIM_BITS-1:0] cell_height_o,
  output logic [CNT_W-1:0]    rows_chosen_o,
  output logic                last_cell_o
);

  localparam int DSR_W = CNT_W + 1;
  localparam int DV_W  = (DIM_BITS > CNT_W) ? DIM_BITS : CNT_W;
  localparam int DC_W  = $clog2(DV_W + 1);
  localparam int MB_W  = (DIM_BITS > DSR_W) ? DIM_BITS : DSR_W;
  localparam int PW    = 2 * DIM_BITS + MB_W;
  localparam int SC_W  = 2 * DIM_BITS + CNT_W + 1;
  localparam int BS_W  = (SC_W > 31) ? SC_W : 31;

  grl_pkg::grl_state_e state_q, state_d, ret_q, ret_d;

  logic [CNT_W-1:0]    n_q, n_d;
  logic [DIM_BITS-1:0] w_q, w_d, h_q, h_d;
  logic [CNT_W-1:0]    r_q, r_d, best_r_q, best_r_d;
  logic [BS_W-1:0]     best_s_q, best_s_d;
  logic [CNT_W-1:0]    base_q, base_d, extra_q, extra_d, n1_q, n1_d;
  logic [DIM_BITS-1:0] rh_q, rh_d, rhx_q, rhx_d, w1_q, w1_d, w23_q, w23_d;
  logic [1:0]          term_q, term_d;
  logic [SC_W-1:0]     acc_q, acc_d;
  // divider
  logic [DV_W-1:0]     dvd_q, dvd_d;
  logic [DSR_W-1:0]    dsr_q, dsr_d, rem_q, rem_d;
  logic [DC_W-1:0]     dcnt_q, dcnt_d;
  // multiplier
  logic [2*DIM_BITS-1:0] mul_a_q, mul_a_d;
  logic [MB_W-1:0]       mul_b_q, mul_b_d;
  logic [PW-1:0]         prod;
  // layout walk
  logic [CNT_W-1:0]    row_q, row_d, col_q, col_d, cols_q, cols_d, k_q, k_d;
  logic [DIM_BITS-1:0] x_q, x_d, y_q, y_d, cw_q, cw_d;
  logic [DSR_W-1:0]    cwx_q, cwx_d;
  // output register
  logic                ov_q, ov_d, olast_q, olast_d;
  logic [IDX_W-1:0]    oidx_q, oidx_d;
  logic [DIM_BITS-1:0] ox_q, ox_d, oy_q, oy_d, ow_q, ow_d, oh_q, oh_d;
  logic [CNT_W-1:0]    orows_q, orows_d;

  // Shared multiplier
  assign prod = PW'(mul_a_q) * PW'(mul_b_q);

  // Sequencer
  always_comb begin
    logic                div_go;
    logic [DV_W-1:0]     div_a;
    logic [DSR_W-1:0]    div_b;
    grl_pkg::grl_state_e div_ret;
    logic [DSR_W:0]      trial;
    logic                qbit;
    logic [CNT_W-1:0]    n_sat, n2, tcnt, nbr;
    logic [DIM_BITS-1:0] sa, sb, smin, sdiff, tw, th;
    logic [SC_W-1:0]     s;

    state_d = state_q; ret_d = ret_q;
    n_d = n_q; w_d = w_q; h_d = h_q;
    r_d = r_q; best_r_d = best_r_q; best_s_d = best_s_q;
    base_d = base_q; extra_d = extra_q; n1_d = n1_q;
    rh_d = rh_q; rhx_d = rhx_q; w1_d = w1_q; w23_d = w23_q;
    term_d = term_q; acc_d = acc_q;
    dvd_d = dvd_q; dsr_d = dsr_q; rem_d = rem_q; dcnt_d = dcnt_q;
    mul_a_d = mul_a_q; mul_b_d = mul_b_q;
    row_d = row_q; col_d = col_q; cols_d = cols_q; k_d = k_q;
    x_d = x_q; y_d = y_q; cw_d = cw_q; cwx_d = cwx_q;
    ov_d = ov_q; olast_d = olast_q; oidx_d = oidx_q;
    ox_d = ox_q; oy_d = oy_q; ow_d = ow_q; oh_d = oh_q; orows_d = orows_q;
    div_go = 1'b0; div_a = '0; div_b = '0; div_ret = grl_pkg::ST_IDLE;
    trial = '0; qbit = 1'b0; n_sat = '0; nbr = best_r_q;
    s = '0; tw = '0; th = '0;

    // Output register drains on a taken item
    if (ov_q && !out_stall_i) ov_d = 1'b0;

    // Score term operands
    n2    = n_q - n1_q - base_q;
    sa    = (term_q == 2'd0) ? w1_q : w23_q;
    sb    = (term_q == 2'd2) ? rh_q + rhx_q : rh_q;
    smin  = (sa > sb) ? sb : sa;
    sdiff = (sa > sb) ? sa - sb : sb - sa;
    tcnt  = (term_q == 2'd0) ? n1_q : ((term_q == 2'd1) ? n2 : base_q);

    case (state_q)
      grl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          n_sat = (cell_count_i > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : cell_count_i;
          n_d = n_sat; w_d = area_width_i; h_d = area_height_i;
          best_r_d = CNT_W'(1); r_d = CNT_W'(1);
          best_s_d = BS_W'(grl_pkg::IntMax);
          if (n_sat != '0) begin
            div_go = 1'b1;
            div_a  = DV_W'(n_sat);
            div_b  = DSR_W'(1);
            if (n_sat == CNT_W'(1) || area_width_i == '0 || area_height_i == '0) begin
              div_ret = grl_pkg::ST_LY_BASE;
            end else begin
              div_ret = grl_pkg::ST_SC_BASE;
            end
          end
        end
      end
      // one quotient bit per cycle
      grl_pkg::ST_DIV: begin
        trial = {rem_q, dvd_q[DV_W-1]};
        qbit  = (trial >= {1'b0, dsr_q});
        rem_d = qbit ? DSR_W'(trial - {1'b0, dsr_q}) : DSR_W'(trial);
        dvd_d = {dvd_q[DV_W-2:0], qbit};
        dcnt_d = dcnt_q - DC_W'(1);
        if (dcnt_q == DC_W'(1)) state_d = ret_q;
      end
      grl_pkg::ST_SC_BASE: begin
        base_d  = CNT_W'(dvd_q);
        extra_d = CNT_W'(rem_q);
        div_go = 1'b1; div_a = DV_W'(h_q); div_b = DSR_W'(r_q);
        div_ret = grl_pkg::ST_SC_RH;
      end
      grl_pkg::ST_SC_RH: begin
        rh_d  = DIM_BITS'(dvd_q);
        rhx_d = DIM_BITS'(rem_q);
        div_go = 1'b1; div_a = DV_W'(w_q); div_b = DSR_W'(base_q) + DSR_W'(1);
        div_ret = grl_pkg::ST_SC_W1;
      end
      grl_pkg::ST_SC_W1: begin
        w1_d = DIM_BITS'(dvd_q);
        div_go = 1'b1; div_a = DV_W'(w_q); div_b = DSR_W'(base_q);
        div_ret = grl_pkg::ST_SC_W23;
      end
      grl_pkg::ST_SC_W23: begin
        w23_d   = DIM_BITS'(dvd_q);
        mul_a_d = (2*DIM_BITS)'(extra_q);
        mul_b_d = MB_W'(base_q) + MB_W'(1);
        state_d = grl_pkg::ST_SC_N1;
      end
      grl_pkg::ST_SC_N1: begin
        n1_d   = CNT_W'(prod);
        term_d = 2'd0;
        acc_d  = '0;
        state_d = grl_pkg::ST_SC_SQ;
      end
      // area outside the inscribed square
      grl_pkg::ST_SC_SQ: begin
        mul_a_d = (2*DIM_BITS)'(smin);
        mul_b_d = MB_W'(sdiff);
        state_d = grl_pkg::ST_SC_CNT;
      end
      // scale by the number of such cells
      grl_pkg::ST_SC_CNT: begin
        mul_a_d = prod[2*DIM_BITS-1:0];
        mul_b_d = MB_W'(tcnt);
        state_d = grl_pkg::ST_SC_ACC;
      end
      grl_pkg::ST_SC_ACC: begin
        acc_d  = acc_q + SC_W'(prod);
        term_d = term_q + 2'd1;
        state_d = (term_q == 2'd2) ? grl_pkg::ST_SC_CMP : grl_pkg::ST_SC_SQ;
      end
      // keep the first lowest score
      grl_pkg::ST_SC_CMP: begin
        s = (extra_q != '0) ? {acc_q[SC_W-2:0], 1'b0} : acc_q;
        if (BS_W'(s) < best_s_q) begin
          best_s_d = BS_W'(s);
          best_r_d = r_q;
          nbr      = r_q;
        end
        div_go = 1'b1;
        div_a  = DV_W'(n_q);
        if (r_q == n_q) begin
          div_b = DSR_W'(nbr);
          div_ret = grl_pkg::ST_LY_BASE;
        end else begin
          r_d   = r_q + CNT_W'(1);
          div_b = DSR_W'(r_q) + DSR_W'(1);
          div_ret = grl_pkg::ST_SC_BASE;
        end
      end
      grl_pkg::ST_LY_BASE: begin
        base_d  = CNT_W'(dvd_q);
        extra_d = CNT_W'(rem_q);
        div_go = 1'b1; div_a = DV_W'(h_q); div_b = DSR_W'(best_r_q);
        div_ret = grl_pkg::ST_LY_RH;
      end
      grl_pkg::ST_LY_RH: begin
        rh_d  = DIM_BITS'(dvd_q);
        rhx_d = DIM_BITS'(rem_q);
        row_d = '0; y_d = '0; k_d = '0;
        state_d = grl_pkg::ST_LY_ROW;
      end
      // top rows take the extra columns
      grl_pkg::ST_LY_ROW: begin
        cols_d = base_q + ((row_q < extra_q) ? CNT_W'(1) : CNT_W'(0));
        div_go = 1'b1; div_a = DV_W'(w_q); div_b = DSR_W'(cols_d);
        div_ret = grl_pkg::ST_LY_COLW;
      end
      grl_pkg::ST_LY_COLW: begin
        cw_d  = DIM_BITS'(dvd_q);
        cwx_d = rem_q;
        col_d = '0; x_d = '0;
        state_d = grl_pkg::ST_LY_EMIT;
      end
      // one rectangle per cycle while the output register is free
      grl_pkg::ST_LY_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          tw = cw_q + ((DSR_W'(col_q) < cwx_q) ? DIM_BITS'(1) : DIM_BITS'(0));
          th = rh_q + ((row_q == best_r_q - CNT_W'(1)) ? rhx_q : DIM_BITS'(0));
          ov_d = 1'b1;
          oidx_d = IDX_W'(k_q);
          ox_d = x_q; oy_d = y_q; ow_d = tw; oh_d = th;
          orows_d = best_r_q;
          olast_d = ({1'b0, k_q} + (CNT_W+1)'(1)) == {1'b0, n_q};
          x_d = x_q + tw;
          k_d = k_q + CNT_W'(1);
          if (col_q == cols_q - CNT_W'(1)) begin
            y_d = y_q + th;
            if (row_q == best_r_q - CNT_W'(1)) begin
              state_d = grl_pkg::ST_IDLE;
            end else begin
              row_d = row_q + CNT_W'(1);
              state_d = grl_pkg::ST_LY_ROW;
            end
          end else begin
            col_d = col_q + CNT_W'(1);
          end
        end
      end
      default: state_d = grl_pkg::ST_IDLE;
    endcase

    // Start a division and come back afterwards
    if (div_go) begin
      dvd_d   = div_a;
      dsr_d   = div_b;
      rem_d   = '0;
      dcnt_d  = DC_W'(DV_W);
      ret_d   = div_ret;
      state_d = grl_pkg::ST_DIV;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grl_pkg::ST_IDLE;
      ret_q   <= grl_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q <= n_d; w_q <= w_d; h_q <= h_d;
    r_q <= r_d; best_r_q <= best_r_d; best_s_q <= best_s_d;
    base_q <= base_d; extra_q <= extra_d; n1_q <= n1_d;
    rh_q <= rh_d; rhx_q <= rhx_d; w1_q <= w1_d; w23_q <= w23_d;
    term_q <= term_d; acc_q <= acc_d;
    dvd_q <= dvd_d; dsr_q <= dsr_d; rem_q <= rem_d; dcnt_q <= dcnt_d;
    mul_a_q <= mul_a_d; mul_b_q <= mul_b_d;
    row_q <= row_d; col_q <= col_d; cols_q <= cols_d; k_q <= k_d;
    x_q <= x_d; y_q <= y_d; cw_q <= cw_d; cwx_q <= cwx_d;
    olast_q <= olast_d; oidx_q <= oidx_d;
    ox_q <= ox_d; oy_q <= oy_d; ow_q <= ow_d; oh_q <= oh_d; orows_q <= orows_d;
  end

  assign in_stall_o    = (state_q != grl_pkg::ST_IDLE);
  assign out_valid_o   = ov_q;
  assign cell_index_o  = oidx_q;
  assign cell_x_o      = ox_q;
  assign cell_y_o      = oy_q;
  assign cell_width_o  = ow_q;
  assign cell_height_o = oh_q;
  assign rows_chosen_o = orows_q;
  assign last_cell_o   = olast_q;

endmodule

@@ sv/grl_checker.sv @@
// ----------------------------------------------------------------------------
// grl_checker
// Port-level checks for the grid layout row chooser.
// ----------------------------------------------------------------------------
module grl_checker #(
  parameter int MAX_CELLS = grl_pkg::MaxCellsDef,
  localparam int CNT_W    = $clog2(MAX_CELLS + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [CNT_W-1:0] cell_count_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             last_cell_o,
  input logic [CNT_W-1:0] rows_chosen_o
);

  // A stalled item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A nonempty request keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cell_count_i != '0 |=> in_stall_o)
    else $error("request accepted but block not busy");

  // Cells still owed keep the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_cell_o |-> in_stall_o)
    else $error("new request taken before the last cell");

  // Every rectangle carries a real row count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rows_chosen_o != '0)
    else $error("zero row count on output");

endmodule

bind grid_layout_row_chooser grl_checker #(.MAX_CELLS(MAX_CELLS)) u_grl_checker (.*);

@@ sim/tb_grid_layout_row_chooser.sv @@
// ----------------------------------------------------------------------------
// tb_grid_layout_row_chooser
// Self-checking bench for the grid layout row chooser. Layout requests are
// sent with bursty timing. A local model predicts every rectangle, and each
// rectangle taken from the block is checked against it in order. The output
// side stalls at random and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_grid_layout_row_chooser;

  localparam int CntW      = 5;
  localparam int IdxW      = 4;
  localparam int DimW      = grl_pkg::DimBitsDef;
  localparam int IdleLimit = 8000;
  localparam int DrainWait = 1500;
  localparam int HoldLen   = 1500;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [CntW-1:0] rows;
    logic            last;
  } rect_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [CntW-1:0] cell_count_i;
  logic [DimW-1:0] area_width_i;
  logic [DimW-1:0] area_height_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [IdxW-1:0] cell_index_o;
  logic [DimW-1:0] cell_x_o;
  logic [DimW-1:0] cell_y_o;
  logic [DimW-1:0] cell_width_o;
  logic [DimW-1:0] cell_height_o;
  logic [CntW-1:0] rows_chosen_o;
  logic            last_cell_o;

  rect_t expected_rects[$];
  int    mismatches;
  int    rects_seen;
  int    reqs_sent;
  int    idle_cycles;
  // sender burst shaping, receiver stall shaping
  int    burst_left;
  bit    sender_gaps;
  int    stall_pct;
  bit    hold_req;
  bit    hold_taken;
  int    hold_cycles;

  grid_layout_row_chooser u_dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- layout predictor ----------------
  function automatic longint unsigned square_waste(longint unsigned a, longint unsigned b);
    return (a > b) ? b * (a - b) : a * (b - a);
  endfunction

  function automatic longint unsigned rows_score(longint unsigned n, longint unsigned w,
                                                 longint unsigned h, longint unsigned r);
    longint unsigned base, extra, rh, rh_last, n1, n2, n3, s;
    base    = n / r;
    extra   = n % r;
    rh      = h / r;
    rh_last = rh + h % r;
    n1      = extra * (base + 1);
    n3      = base;
    n2      = n - n1 - n3;
    s = n1 * square_waste(w / (base + 1), rh) + n2 * square_waste(w / base, rh)
        + n3 * square_waste(w / base, rh_last);
    if (extra != 0) s = s * 2;
    return s;
  endfunction

  function automatic longint unsigned best_rows(longint unsigned n, longint unsigned w,
                                                longint unsigned h);
    longint unsigned r_best, s_best, s;
    r_best = 1;
    s_best = 64'(grl_pkg::IntMax);
    if (n <= 1 || w == 0 || h == 0) return 1;
    for (longint unsigned r = 1; r <= n; r++) begin
      s = rows_score(n, w, h, r);
      if (s < s_best) begin
        s_best = s;
        r_best = r;
      end
    end
    return r_best;
  endfunction

  // Push every rectangle one request produces, in row-major order
  task automatic predict_layout(logic [CntW-1:0] cnt, logic [DimW-1:0] wd,
                                logic [DimW-1:0] ht);
    longint unsigned n, w, h, rows, base, extra, rh, y, k, this_h, cols, cw, cw_x, x, this_w;
    rect_t r;
    n = cnt;
    w = wd;
    h = ht;
    y = 0;
    k = 0;
    if (n > grl_pkg::MaxCellsDef) n = grl_pkg::MaxCellsDef;
    if (n == 0) return;
    rows  = best_rows(n, w, h);
    base  = n / rows;
    extra = n % rows;
    rh    = h / rows;
    for (longint unsigned row = 0; row < rows; row++) begin
      this_h = rh + ((row == rows - 1) ? h % rows : 0);
      cols   = base + ((row < extra) ? 1 : 0);
      cw     = w / cols;
      cw_x   = w % cols;
      x      = 0;
      for (longint unsigned col = 0; col < cols; col++) begin
        this_w = cw + ((col < cw_x) ? 1 : 0);
        r.idx  = k[IdxW-1:0];
        r.x    = x[DimW-1:0];
        r.y    = y[DimW-1:0];
        r.w    = this_w[DimW-1:0];
        r.h    = this_h[DimW-1:0];
        r.rows = rows[CntW-1:0];
        r.last = (k + 1 == n);
        expected_rects.push_back(r);
        x += this_w;
        k++;
      end
      y += this_h;
    end
  endtask

  // ---------------- request driver ----------------
  task automatic send_request(logic [CntW-1:0] cnt, logic [DimW-1:0] wd, logic [DimW-1:0] ht);
    int gap;
    // gap between bursts
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(1, 40);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cell_count_i  <= cnt;
    area_width_i  <= wd;
    area_height_i <= ht;
    do @(posedge clk_i); while (in_stall_o);
    predict_layout(cnt, wd, ht);
    reqs_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Random dimension: full range, small, or an edge value
  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DimW'($urandom_range(1, 64));
      default: return DimW'($urandom);
    endcase
  endfunction

  function automatic logic [CntW-1:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return CntW'($urandom_range(17, 31));
      3, 4:    return CntW'($urandom_range(1, 3));
      default: return CntW'($urandom_range(1, 16));
    endcase
  endfunction

  // ---------------- receiver stall ----------------
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cycles <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      // start the long hold-off
      out_stall_i <= 1'b1;
      hold_cycles <= HoldLen - 1;
      hold_taken  <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------- rectangle checker ----------------
  always @(posedge clk_i) begin
    rect_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{cell_index_o, cell_x_o, cell_y_o, cell_width_o, cell_height_o,
              rows_chosen_o, last_cell_o};
      rects_seen++;
      if (expected_rects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected rectangle %p", got);
      end else begin
        want = expected_rects.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: rectangle mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog: cycles with nothing moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("ERROR: no progress for %0d cycles", IdleLimit);
      $display("tb_grid_layout_row_chooser: FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic wait_drained();
    while (expected_rects.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edge_requests();
    sender_gaps = 1'b0;
    stall_pct   = 0;
    send_request(5'd0, 12'd100, 12'd100);     // empty request
    send_request(5'd1, 12'd4095, 12'd4095);   // single cell
    send_request(5'd16, 12'd4095, 12'd4095);  // full grid, largest area
    send_request(5'd17, 12'd640, 12'd480);    // saturates
    send_request(5'd31, 12'd1, 12'd4095);     // saturates, tall sliver
    send_request(5'd4, 12'd0, 12'd300);       // zero width
    send_request(5'd5, 12'd300, 12'd0);       // zero height
    send_request(5'd7, 12'd0, 12'd0);
    send_request(5'd16, 12'd4095, 12'd1);     // wide sliver
    send_request(5'd16, 12'd1, 12'd1);        // fewer pixels than cells
    send_request(5'd3, 12'd10, 12'd7);        // uneven rows, spare pixels
    send_request(5'd5, 12'd1000, 12'd1003);
    send_request(5'd2, 12'd2730, 12'd1365);
    send_request(5'd10, 12'd1111, 12'd2222);
    send_request(5'd13, 12'd2048, 12'd2047);
    release_input();
    wait_drained();
  endtask

  task automatic test_random_requests(int count);
    sender_gaps = 1'b1;
    burst_left  = 0;
    for (int i = 0; i < count; i++) begin
      // alternate stall pressure between phases
      if (i % 40 == 0) stall_pct = (i % 80 == 0) ? 30 : 0;
      send_request(pick_count(), pick_dim(), pick_dim());
    end
    release_input();
    wait_drained();
  endtask

  // Hold the output off while requests keep coming so the input stalls
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    stall_pct   = 10;
    hold_req    = 1'b1;
    for (int i = 0; i < 8; i++) send_request(CntW'($urandom_range(2, 16)), pick_dim(), pick_dim());
    release_input();
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cell_count_i  = '0;
    area_width_i  = '0;
    area_height_i = '0;
    reqs_sent     = 0;
    burst_left    = 0;
    sender_gaps   = 1'b0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edge_requests();
    test_output_backpressure();
    test_random_requests(130);

    // let any trailing empty request finish
    repeat (DrainWait) @(posedge clk_i);
    $display("Run covered %0d layout requests and %0d rectangles,", reqs_sent, rects_seen);
    $display("with edge sizes, saturated counts and output backpressure.");
    if (mismatches == 0 && expected_rects.size() == 0) begin
      $display("tb_grid_layout_row_chooser: PASS");
    end else begin
      $display("%0d mismatches, %0d rectangles missing", mismatches, expected_rects.size());
      $display("tb_grid_layout_row_chooser: FAIL");
    end
    $finish;
  end

endmodule
